// ----- design/message_fifo_with_overflow_count_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the message FIFO
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_FIFO_WITH_OVERFLOW_COUNT_MACROS_SVH
`define MESSAGE_FIFO_WITH_OVERFLOW_COUNT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge out of reset
`define MFOC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// condition must never be seen at an edge out of reset
`define MFOC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error(msg);

`else

`define MFOC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFOC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- design/mfoc_pkg.sv -----
// ---------------------------------------------------------------------------
// Message FIFO package
// Sizes, request and status codes, payload and control types.
// ---------------------------------------------------------------------------
`default_nettype none

package mfoc_pkg;

	localparam int DEPTH      = 64;
	localparam int ELEM_WIDTH = 64;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int QSIZE_W    = 7;
	localparam int RESET_SIZE = (DEPTH < 64) ? DEPTH : 64;

	typedef enum logic [1:0] {
		REQ_ENQ = 2'd0,
		REQ_DEQ = 2'd1,
		REQ_CLR = 2'd2,
		REQ_NOP = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_code_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] msg_data;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] msg_out;
		logic [6:0]  fill_count;
		logic        overflow_flag;
		logic [31:0] overflow_count;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       enq;
		logic       deq;
		logic       clr;
		logic       refuse;
		logic       load_now;
		logic       load_mem;
		logic [1:0] status;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- design/mfoc_ctrl.sv -----
// ---------------------------------------------------------------------------
// Message FIFO controller
// Decodes requests, sequences the storage read and owns the result valid.
// ---------------------------------------------------------------------------
`default_nettype none

`include "message_fifo_with_overflow_count_macros.svh"

module mfoc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	input  wire  [1:0]          req_type,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	input  wire mfoc_pkg::dp_stat_t stat,
	output mfoc_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   is_enq, is_deq, is_clr;

	assign req_stall = (state_q != S_IDLE) || (out_valid_q && rsp_stall);
	assign rsp_valid = out_valid_q;

	assign is_enq = (req_type == mfoc_pkg::REQ_ENQ);
	assign is_deq = (req_type == mfoc_pkg::REQ_DEQ);
	assign is_clr = (req_type == mfoc_pkg::REQ_CLR);

	always_comb begin
		cmd          = '0;
		cmd.accept   = req_valid && !req_stall;
		cmd.enq      = cmd.accept && is_enq && !stat.full;
		cmd.refuse   = cmd.accept && is_enq && stat.full;
		cmd.deq      = cmd.accept && is_deq && !stat.empty;
		cmd.clr      = cmd.accept && is_clr;
		cmd.load_now = cmd.accept && !cmd.deq;
		cmd.load_mem = (state_q == S_READ);
		if (cmd.refuse) begin
			cmd.status = mfoc_pkg::STS_FULL;
		end else if (cmd.accept && is_deq && stat.empty) begin
			cmd.status = mfoc_pkg::STS_EMPTY;
		end else begin
			cmd.status = mfoc_pkg::STS_OK;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.deq) state_nxt = S_READ;
			end
			S_READ: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_now || cmd.load_mem) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the read state always falls back to idle in the following cycle and finds the result register free
	`MFOC_ASSERT(a_read_one_cycle, clk, arst_n, (state_q == S_READ) |=> (state_q == S_IDLE),
		"read state held past one cycle")
	`MFOC_ASSERT(a_read_out_free, clk, arst_n, (state_q == S_READ) |-> !out_valid_q,
		"result register busy during storage read")
	`MFOC_NEVER(a_no_accept_in_read, clk, arst_n, cmd.load_mem && cmd.accept,
		"request taken while a dequeue is in flight")

endmodule

`default_nettype wire

// ----- design/mfoc_datapath.sv -----
// ---------------------------------------------------------------------------
// Message FIFO datapath
// Slot storage, ring indices, fill level, overflow tally and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "message_fifo_with_overflow_count_macros.svh"

module mfoc_datapath (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [mfoc_pkg::QSIZE_W-1:0]      cfg_wdata,
	input  wire  [mfoc_pkg::ELEM_WIDTH-1:0]   wdata,
	input  wire mfoc_pkg::ctrl_cmd_t          cmd,
	output mfoc_pkg::dp_stat_t                stat,
	output mfoc_pkg::rsp_item_t               rsp
);

	localparam int IW = mfoc_pkg::IDX_W;
	localparam int CW = mfoc_pkg::CNT_W;

	logic [mfoc_pkg::ELEM_WIDTH-1:0] mem_q [mfoc_pkg::DEPTH];
	logic [mfoc_pkg::ELEM_WIDTH-1:0] rdata_q;

	logic [CW-1:0] size_q, size_wr;
	logic [IW-1:0] rd_q, wr_q, rd_nxt, wr_nxt, wr_addr;
	logic [CW-1:0] fill_q, fill_nxt;
	logic          ovf_q, ovf_nxt;
	logic [31:0]   tally_q, tally_nxt;
	logic [31:0]   cfg_ext;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
		input logic [CW-1:0] size);
		logic [CW:0] n;
		n = (CW + 1)'(idx) + (CW + 1)'(1);
		return (n >= (CW + 1)'(size)) ? '0 : IW'(n);
	endfunction

	// clamp the written size into 1..DEPTH
	assign cfg_ext = 32'(cfg_wdata);
	always_comb begin
		if (cfg_ext == 32'd0) begin
			size_wr = CW'(1);
		end else if (cfg_ext > 32'(mfoc_pkg::DEPTH)) begin
			size_wr = CW'(mfoc_pkg::DEPTH);
		end else begin
			size_wr = CW'(cfg_ext);
		end
	end

	assign stat = '{empty: (fill_q == '0), full: (fill_q >= size_q)};

	assign wr_addr = stat.empty ? wr_q : next_idx(wr_q, size_q);

	always_comb begin
		rd_nxt    = rd_q;
		wr_nxt    = wr_q;
		fill_nxt  = fill_q;
		ovf_nxt   = ovf_q;
		tally_nxt = tally_q;
		if (cmd.clr) begin
			rd_nxt    = '0;
			wr_nxt    = '0;
			fill_nxt  = '0;
			ovf_nxt   = 1'b0;
			tally_nxt = '0;
		end else if (cmd.enq) begin
			wr_nxt   = wr_addr;
			fill_nxt = fill_q + CW'(1);
			// resync head to the tail when the queue was empty
			if (stat.empty) rd_nxt = wr_q;
		end else if (cmd.deq) begin
			rd_nxt   = next_idx(rd_q, size_q);
			fill_nxt = fill_q - CW'(1);
		end else if (cmd.refuse) begin
			ovf_nxt   = 1'b1;
			tally_nxt = tally_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq) mem_q[wr_addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.deq) rdata_q <= mem_q[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= CW'(mfoc_pkg::RESET_SIZE);
			rd_q    <= '0;
			wr_q    <= '0;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			tally_q <= '0;
		end else begin
			if (cfg_we) size_q <= size_wr;
			rd_q    <= rd_nxt;
			wr_q    <= wr_nxt;
			fill_q  <= fill_nxt;
			ovf_q   <= ovf_nxt;
			tally_q <= tally_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_mem) begin
			rsp.status         <= mfoc_pkg::STS_OK;
			rsp.msg_out        <= 64'(rdata_q);
			rsp.fill_count     <= 7'(fill_q);
			rsp.overflow_flag  <= ovf_q;
			rsp.overflow_count <= tally_q;
		end else if (cmd.load_now) begin
			rsp.status         <= cmd.status;
			rsp.msg_out        <= '0;
			rsp.fill_count     <= 7'(fill_nxt);
			rsp.overflow_flag  <= ovf_nxt;
			rsp.overflow_count <= tally_nxt;
		end
	end

	`MFOC_ASSERT(a_fill_bound, clk, arst_n, 32'(fill_q) <= 32'(mfoc_pkg::DEPTH),
		"fill level beyond storage depth")
	`MFOC_ASSERT(a_tally_needs_flag, clk, arst_n, !ovf_q |-> (tally_q == '0),
		"overflow tally counted without the sticky flag")
	`MFOC_ASSERT(a_size_range, clk, arst_n,
		(size_q != '0) && (32'(size_q) <= 32'(mfoc_pkg::DEPTH)),
		"queue size outside one to depth")

endmodule

`default_nettype wire

// ----- design/message_fifo_with_overflow_count.sv -----
// ---------------------------------------------------------------------------
// Message FIFO with overflow count
// Ring-buffer message queue with a sticky overflow flag and a 32-bit tally.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: req_valid / req_stall with payload req (req_type, msg_data).
//     Kinds are enqueue, dequeue, clear queue; the unused kind only reports.
//   rsp channel: rsp_valid / rsp_stall, one result per request, in order,
//     carrying status, msg_out, fill_count, overflow_flag, overflow_count.
//   cfg_we / cfg_wdata write queue_size (0 reads as 1, above depth clamps);
//     write only while no request is outstanding.
// Results are registered; a dequeue of a held element first reads the slot
//   RAM into a register, then loads the result register from that read.
// Throughput: one request per cycle while req_stall is low.
// The result register lets the next request in while the receiver takes the
//   current result; req_stall rises only while a result sits stalled or a
//   slot read is in flight.
// Reset clears indices, fill level, overflow flag and tally and sets the
//   size to the full depth; slot contents are not cleared, no sweep runs.
// ---------------------------------------------------------------------------
`default_nettype none

module message_fifo_with_overflow_count (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [mfoc_pkg::QSIZE_W-1:0]  cfg_wdata,
	input  wire                           req_valid,
	output logic                          req_stall,
	input  wire mfoc_pkg::req_item_t      req,
	output logic                          rsp_valid,
	input  wire                           rsp_stall,
	output mfoc_pkg::rsp_item_t           rsp
);

	mfoc_pkg::ctrl_cmd_t cmd;
	mfoc_pkg::dp_stat_t  stat;

	mfoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mfoc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.wdata     (req.msg_data[mfoc_pkg::ELEM_WIDTH-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
